// ===== hdl/gda_pkg.sv =====
package gda_pkg;

    typedef logic [13:0] year_t;
    typedef logic [3:0]  month_t;
    typedef logic [4:0]  day_t;

    typedef enum logic [2:0] {
        ACT_LOAD       = 3'd0,
        ACT_ADD_DAYS   = 3'd1,
        ACT_SUB_DAYS   = 3'd2,
        ACT_ADD_MONTHS = 3'd3,
        ACT_SUB_MONTHS = 3'd4,
        ACT_ADD_YEARS  = 3'd5,
        ACT_SUB_YEARS  = 3'd6
    } act_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LDCHK,
        ST_DADD,
        ST_DSUB,
        ST_MB1,
        ST_MB2,
        ST_MOFS,
        ST_MDIV,
        ST_YOFS,
        ST_CLAMP,
        ST_DONE
    } state_t;

    localparam int     YEAR_W    = 14;
    localparam month_t MONTHS    = 4'd12;
    localparam month_t MONTH_FEB = 4'd2;
    localparam day_t   FEB_LEAP  = 5'd29;
    localparam day_t   DEC_DAYS  = 5'd31;

    localparam day_t MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // y is a multiple of 25 exactly when y * inv(25) mod 2^14 <= (2^14 - 1) / 25
    localparam year_t INV25   = 14'd7209;
    localparam year_t D25_MAX = 14'd655;

    // x / 3 equals (x * RECIP3) >> 17 for every 16-bit x
    localparam logic [16:0] RECIP3 = 17'd43691;

    function automatic logic is_leap(year_t y);
        year_t p;
        logic  d25;
        p   = y * INV25;
        d25 = (p <= D25_MAX);
        return (y[1:0] == 2'd0) && (!d25 || (y[3:0] == 4'd0));
    endfunction

    function automatic day_t month_days(month_t m, logic leap);
        day_t   len;
        month_t idx;
        idx = m - 4'd1;
        len = DEC_DAYS;
        if (m >= 4'd1 && m <= MONTHS)
        begin
            len = MONTH_LEN[idx];
        end
        if (m == MONTH_FEB && leap)
        begin
            len = FEB_LEAP;
        end
        return len;
    endfunction

endpackage

// ===== hdl/gda_alu.sv =====
module gda_alu #(
    parameter int W = 19
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] res,
    output logic         borrow
);

    logic [W:0] full;

    assign full   = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
    assign res    = full[W-1:0];
    assign borrow = full[W];

endmodule

// ===== hdl/gda_leap.sv =====
module gda_leap (
    input  logic           clk,
    input  logic           rst_n,
    input  gda_pkg::year_t year,
    input  logic           year_wr,
    output logic           leap,
    output logic           valid
);

    logic leap_reg;
    logic valid_reg;

    always_ff @(posedge clk)
    begin
        leap_reg <= gda_pkg::is_leap(year);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= !year_wr;
        end
    end

    assign leap  = leap_reg;
    assign valid = valid_reg;

endmodule

// ===== hdl/gregorian_date_adder.sv =====
// Gregorian date adder. Holds one date (reset value 0001-01-01) and, per input word, loads a
// date or moves it by a count of days, months or years; one result word follows each input
// word, with the held date and an error flag that is set when a load is not a valid date, the
// year would leave 0..MAX_YEAR, or the action code is unused (the date then stays as it was).
// Items are taken one at a time; s_tready is high only between items. Each item is worked
// through by a sequencer around the shared add/subtract unit; a day step walks the date one
// month at a time and waits for the leap flag again at each year boundary crossed. The result
// register lets the next word enter while a result waits.
module gregorian_date_adder #(
    parameter int MAX_YEAR    = 9999,
    parameter int AMOUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // amount[15:0], load_year[13:0], load_month[3:0], load_day[4:0]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // cur_year[13:0], cur_month[3:0], cur_day[4:0], zero pad
    output logic [0:0]  m_tuser    // range_error
);

    localparam int DW = (AMOUNT_BITS > 18) ? AMOUNT_BITS + 1 : 19;
    typedef logic [DW-1:0] wide_t;

    localparam wide_t AMT_MASK  = wide_t'((64'd1 << AMOUNT_BITS) - 64'd1);
    localparam wide_t MONTH_LIM = wide_t'((MAX_YEAR + 1) * 12 - 1);
    localparam wide_t YEAR_LIM  = wide_t'(MAX_YEAR);
    localparam gda_pkg::year_t YEAR_MAX = gda_pkg::year_t'(MAX_YEAR);

    gda_pkg::state_t state_reg, state_next;
    gda_pkg::act_t   act_reg, act_next;
    logic            err_reg, err_next;
    logic            ov_reg, ov_next;
    logic            oe_reg, oe_next;
    gda_pkg::year_t  yr_reg, yr_next, hy_reg, hy_next, oy_reg, oy_next;
    gda_pkg::month_t mo_reg, mo_next, hm_reg, hm_next, om_reg, om_next;
    gda_pkg::day_t   dy_reg, dy_next, hd_reg, hd_next, od_reg, od_next;
    wide_t           rem_reg, rem_next, amt_reg, amt_next;

    wide_t           alu_a, alu_b, alu_res, amt_in;
    logic            alu_sub, alu_borrow;
    logic            yr_wr, leap, leap_valid;
    gda_pkg::day_t   dim, gap1;
    logic [15:0]     quot_in;
    logic [32:0]     quot_prod;
    logic [1:0]      rem3;

    gda_alu #(.W(DW)) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    gda_leap u_leap (
        .clk     (clk),
        .rst_n   (rst_n),
        .year    (yr_reg),
        .year_wr (yr_wr),
        .leap    (leap),
        .valid   (leap_valid)
    );

    assign amt_in   = wide_t'(s_tdata[15:0]) & AMT_MASK;
    assign dim      = gda_pkg::month_days(mo_reg, leap);
    assign gap1     = dim - dy_reg + 5'd1;

    // month count / 12 as (count / 4) / 3; the remainder by 3 follows from the low bits
    assign quot_in   = rem_reg[17:2];
    assign quot_prod = 33'(quot_in) * 33'(gda_pkg::RECIP3);
    assign rem3      = quot_in[1:0] + quot_prod[18:17];

    assign s_tready = (state_reg == gda_pkg::ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, od_reg, om_reg, oy_reg};
    assign m_tuser  = oe_reg;

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        err_next   = err_reg;
        ov_next    = ov_reg && !m_tready;
        oe_next    = oe_reg;
        yr_next    = yr_reg;
        mo_next    = mo_reg;
        dy_next    = dy_reg;
        hy_next    = hy_reg;
        hm_next    = hm_reg;
        hd_next    = hd_reg;
        oy_next    = oy_reg;
        om_next    = om_reg;
        od_next    = od_reg;
        rem_next   = rem_reg;
        amt_next   = amt_reg;
        alu_a      = rem_reg;
        alu_b      = amt_reg;
        alu_sub    = 1'b1;
        yr_wr      = 1'b0;

        case (state_reg)
            gda_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next = gda_pkg::act_t'(s_tuser);
                    amt_next = amt_in;
                    rem_next = amt_in;
                    err_next = 1'b0;
                    yr_next  = hy_reg;
                    mo_next  = hm_reg;
                    dy_next  = hd_reg;
                    yr_wr    = 1'b1;
                    case (gda_pkg::act_t'(s_tuser))
                        gda_pkg::ACT_LOAD:
                        begin
                            yr_next    = s_tdata[29:16];
                            mo_next    = s_tdata[33:30];
                            dy_next    = s_tdata[38:34];
                            state_next = gda_pkg::ST_LDCHK;
                        end
                        gda_pkg::ACT_ADD_DAYS:   state_next = gda_pkg::ST_DADD;
                        gda_pkg::ACT_SUB_DAYS:   state_next = gda_pkg::ST_DSUB;
                        gda_pkg::ACT_ADD_MONTHS: state_next = gda_pkg::ST_MB1;
                        gda_pkg::ACT_SUB_MONTHS: state_next = gda_pkg::ST_MB1;
                        gda_pkg::ACT_ADD_YEARS:  state_next = gda_pkg::ST_YOFS;
                        gda_pkg::ACT_SUB_YEARS:  state_next = gda_pkg::ST_YOFS;
                        default:
                        begin
                            err_next   = 1'b1;
                            state_next = gda_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            gda_pkg::ST_LDCHK:
            begin
                if (leap_valid)
                begin
                    err_next = (yr_reg > YEAR_MAX) || (mo_reg == 4'd0) ||
                               (mo_reg > gda_pkg::MONTHS) || (dy_reg == 5'd0) ||
                               (dy_reg > dim);
                    state_next = gda_pkg::ST_DONE;
                end
            end

            gda_pkg::ST_DADD:
            begin
                alu_b = wide_t'(gap1);
                if (leap_valid)
                begin
                    if (alu_borrow)
                    begin
                        dy_next    = dy_reg + rem_reg[4:0];
                        state_next = gda_pkg::ST_DONE;
                    end
                    else if (mo_reg == gda_pkg::MONTHS && yr_reg == YEAR_MAX)
                    begin
                        err_next   = 1'b1;
                        state_next = gda_pkg::ST_DONE;
                    end
                    else
                    begin
                        rem_next = alu_res;
                        dy_next  = 5'd1;
                        if (mo_reg == gda_pkg::MONTHS)
                        begin
                            mo_next = 4'd1;
                            yr_next = yr_reg + 14'd1;
                            yr_wr   = 1'b1;
                        end
                        else
                        begin
                            mo_next = mo_reg + 4'd1;
                        end
                    end
                end
            end

            gda_pkg::ST_DSUB:
            begin
                alu_b = wide_t'(dy_reg);
                if (leap_valid)
                begin
                    if (alu_borrow)
                    begin
                        dy_next    = dy_reg - rem_reg[4:0];
                        state_next = gda_pkg::ST_DONE;
                    end
                    else if (mo_reg == 4'd1 && yr_reg == 14'd0)
                    begin
                        err_next   = 1'b1;
                        state_next = gda_pkg::ST_DONE;
                    end
                    else
                    begin
                        rem_next = alu_res;
                        if (mo_reg == 4'd1)
                        begin
                            mo_next = gda_pkg::MONTHS;
                            dy_next = gda_pkg::DEC_DAYS;
                            yr_next = yr_reg - 14'd1;
                            yr_wr   = 1'b1;
                        end
                        else
                        begin
                            mo_next = mo_reg - 4'd1;
                            dy_next = gda_pkg::month_days(mo_reg - 4'd1, leap);
                        end
                    end
                end
            end

            gda_pkg::ST_MB1:
            begin
                alu_a      = wide_t'({yr_reg, 3'b000});
                alu_b      = wide_t'({yr_reg, 2'b00});
                alu_sub    = 1'b0;
                rem_next   = alu_res;
                state_next = gda_pkg::ST_MB2;
            end

            gda_pkg::ST_MB2:
            begin
                alu_b      = wide_t'(mo_reg - 4'd1);
                alu_sub    = 1'b0;
                rem_next   = alu_res;
                state_next = gda_pkg::ST_MOFS;
            end

            gda_pkg::ST_MOFS:
            begin
                alu_sub = (act_reg == gda_pkg::ACT_SUB_MONTHS);
                if ((alu_sub && alu_borrow) || (!alu_sub && alu_res > MONTH_LIM))
                begin
                    err_next   = 1'b1;
                    state_next = gda_pkg::ST_DONE;
                end
                else
                begin
                    rem_next   = alu_res;
                    state_next = gda_pkg::ST_MDIV;
                end
            end

            gda_pkg::ST_MDIV:
            begin
                yr_next    = quot_prod[30:17];
                mo_next    = {rem3, rem_reg[1:0]} + 4'd1;
                yr_wr      = 1'b1;
                state_next = gda_pkg::ST_CLAMP;
            end

            gda_pkg::ST_YOFS:
            begin
                alu_a   = wide_t'(yr_reg);
                alu_sub = (act_reg == gda_pkg::ACT_SUB_YEARS);
                if ((alu_sub && alu_borrow) || (!alu_sub && alu_res > YEAR_LIM))
                begin
                    err_next   = 1'b1;
                    state_next = gda_pkg::ST_DONE;
                end
                else
                begin
                    yr_next    = alu_res[gda_pkg::YEAR_W-1:0];
                    yr_wr      = 1'b1;
                    state_next = gda_pkg::ST_CLAMP;
                end
            end

            gda_pkg::ST_CLAMP:
            begin
                if (leap_valid)
                begin
                    if (dy_reg > dim)
                    begin
                        dy_next = dim;
                    end
                    state_next = gda_pkg::ST_DONE;
                end
            end

            gda_pkg::ST_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    oe_next = err_reg;
                    if (err_reg)
                    begin
                        oy_next = hy_reg;
                        om_next = hm_reg;
                        od_next = hd_reg;
                    end
                    else
                    begin
                        hy_next = yr_reg;
                        hm_next = mo_reg;
                        hd_next = dy_reg;
                        oy_next = yr_reg;
                        om_next = mo_reg;
                        od_next = dy_reg;
                    end
                    state_next = gda_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = gda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gda_pkg::ST_IDLE;
            err_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            hy_reg    <= 14'd1;
            hm_reg    <= 4'd1;
            hd_reg    <= 5'd1;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
            hy_reg    <= hy_next;
            hm_reg    <= hm_next;
            hd_reg    <= hd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        yr_reg  <= yr_next;
        mo_reg  <= mo_next;
        dy_reg  <= dy_next;
        oy_reg  <= oy_next;
        om_reg  <= om_next;
        od_reg  <= od_next;
        oe_reg  <= oe_next;
        rem_reg <= rem_next;
        amt_reg <= amt_next;
    end

    a_held_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (hm_reg >= 4'd1) && (hm_reg <= gda_pkg::MONTHS) && (hd_reg >= 5'd1) &&
        (hd_reg <= gda_pkg::month_days(hm_reg, gda_pkg::is_leap(hy_reg))))
        else $error("held date is not a valid calendar date");

    a_held_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        hy_reg <= YEAR_MAX)
        else $error("held year above range");

    a_error_keeps_date: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gda_pkg::ST_DONE && err_reg && (!ov_reg || m_tready))
        |=> $stable(hy_reg) && $stable(hm_reg) && $stable(hd_reg))
        else $error("rejected step changed the held date");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != gda_pkg::ST_IDLE))
        else $error("accepted word did not start the sequencer");

endmodule
